### src/lut3d_tetrahedral_color_map_macros.svh
// Assertion macros for the 3D LUT color mapper.
// No dependencies; included by the top-level RTL file, which carries the assertions.
`ifndef LUT3D_TETRAHEDRAL_COLOR_MAP_MACROS_SVH
`define LUT3D_TETRAHEDRAL_COLOR_MAP_MACROS_SVH

// Same-cycle implication.
`define LTCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LTCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ltcm_pkg.sv
// Shared types and constants of the 3D LUT color mapper.
// No dependencies.
`default_nettype none
package ltcm_pkg;

	localparam int LEVEL_MAX_DEF = 33;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;

	// Register indexes
	localparam logic [3:0] REG_LEVEL        = 4'd0;
	localparam logic [3:0] REG_STRENGTH     = 4'd1;
	localparam logic [3:0] REG_SCALE_RED    = 4'd2;
	localparam logic [3:0] REG_SCALE_GREEN  = 4'd3;
	localparam logic [3:0] REG_SCALE_BLUE   = 4'd4;
	localparam logic [3:0] REG_OFFSET_RED   = 4'd5;
	localparam logic [3:0] REG_OFFSET_GREEN = 4'd6;
	localparam logic [3:0] REG_OFFSET_BLUE  = 4'd7;

	// Reset values
	localparam logic [5:0]  LEVEL_RST    = 6'd33;
	localparam logic [12:0] STRENGTH_RST = 13'd4096;
	localparam logic [31:0] SCALE_RST    = 32'd2097184;
	localparam logic [31:0] OFFSET_RST   = 32'd0;

	localparam logic [12:0] STRENGTH_ONE = 13'd4096;

	// Action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_MAP   = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] entry_index;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        line_end;
	} req_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic        out_line_end;
	} rsp_t;

endpackage
`default_nettype wire

### src/lut3d_tetrahedral_color_map.sv
// 3D LUT color mapper with tetrahedral interpolation; top level.
// Depends on ltcm_pkg and lut3d_tetrahedral_color_map_macros.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries items. A write item
//   (action 0) stores {blue,green,red} at entry_index; an index at or above
//   LEVEL_MAX^3 is dropped. A map item (action 1) returns one rsp item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the registers;
//   cfg_ready is always high. Write registers only while no map is pending.
// Path: a map item passes stages s1 to s10 and is then pushed into the
//   output queue; rsp_valid rises once the result is in the queue.
// Throughput: one item per cycle while req_ready is high. Each map reads
//   four lattice corners at once from two copies of the table, each with
//   two read ports; writes go to both copies. Writes and reads sit in the
//   same stage, so item order is kept without forwarding.
// Stall: results land in a 16-entry output queue. req_ready falls only when
//   16 map items are accepted and not yet taken, so a stalled receiver
//   backs the stream up without loss.
// Reset: registers go to level 33, strength 4096, scales 2097184, offsets 0.
//   The table is not cleared; entries must be written before they are read.
`default_nettype none
`include "lut3d_tetrahedral_color_map_macros.svh"

module lut3d_tetrahedral_color_map #(
	parameter int LEVEL_MAX = ltcm_pkg::LEVEL_MAX_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  ltcm_pkg::req_t      req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output ltcm_pkg::rsp_t      rsp,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [3:0]           cfg_index,
	input  wire [31:0]          cfg_data
);

	localparam int DEPTH = LEVEL_MAX * LEVEL_MAX * LEVEL_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int FD    = ltcm_pkg::FIFO_DEPTH;
	localparam int FAW   = ltcm_pkg::FIFO_AW;

	// ---------------- configuration ----------------
	logic [5:0]       level_q;
	logic [12:0]      strength_q;
	logic [2:0][31:0] scale_q;
	logic [2:0][31:0] offset_q;
	logic [5:0]       lv;
	logic [11:0]      lv2_q;
	logic [12:0]      str;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= ltcm_pkg::LEVEL_RST;
			strength_q <= ltcm_pkg::STRENGTH_RST;
			scale_q    <= {3{ltcm_pkg::SCALE_RST}};
			offset_q   <= {3{ltcm_pkg::OFFSET_RST}};
		end else if (cfg_valid) begin
			case (cfg_index)
				ltcm_pkg::REG_LEVEL:        level_q     <= cfg_data[5:0];
				ltcm_pkg::REG_STRENGTH:     strength_q  <= cfg_data[12:0];
				ltcm_pkg::REG_SCALE_RED:    scale_q[0]  <= cfg_data;
				ltcm_pkg::REG_SCALE_GREEN:  scale_q[1]  <= cfg_data;
				ltcm_pkg::REG_SCALE_BLUE:   scale_q[2]  <= cfg_data;
				ltcm_pkg::REG_OFFSET_RED:   offset_q[0] <= cfg_data;
				ltcm_pkg::REG_OFFSET_GREEN: offset_q[1] <= cfg_data;
				ltcm_pkg::REG_OFFSET_BLUE:  offset_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective level and strength; level squared is registered
	always_comb begin
		if (level_q < 6'd2)
			lv = 6'd2;
		else if ({1'b0, level_q} > 7'(LEVEL_MAX))
			lv = 6'(LEVEL_MAX);
		else
			lv = level_q;
		str = (strength_q > ltcm_pkg::STRENGTH_ONE) ? ltcm_pkg::STRENGTH_ONE : strength_q;
	end

	always_ff @(posedge clk) begin
		lv2_q <= 12'(lv) * 12'(lv);
	end

	// ---------------- credit and output queue ----------------
	logic [FAW:0] cnt_q;
	logic [FAW:0] fill_q;
	logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
	ltcm_pkg::rsp_t fifo_q [FD];
	logic push, pop, acc_map;
	ltcm_pkg::rsp_t push_data;

	assign req_ready = (cnt_q < (FAW+1)'(FD));
	assign acc_map   = req_valid && req_ready && (req.action == ltcm_pkg::ACT_MAP);
	assign rsp_valid = (fill_q != '0);
	assign rsp       = fifo_q[rd_ptr_q];
	assign pop       = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			fill_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			cnt_q  <= cnt_q + (FAW+1)'(acc_map) - (FAW+1)'(pop);
			fill_q <= fill_q + (FAW+1)'(push) - (FAW+1)'(pop);
			if (push)
				wr_ptr_q <= wr_ptr_q + FAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FAW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_data;
	end

	// ---------------- pipeline valid flags ----------------
	// m_q: map item in stage, w_q: write item in stage (index = stage - 1)
	logic [9:0] m_q;
	logic [5:0] w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			w_q <= '0;
		end else begin
			m_q <= {m_q[8:0], acc_map};
			w_q <= {w_q[4:0], req_valid && req_ready && (req.action == ltcm_pkg::ACT_WRITE)};
		end
	end

	// ---------------- s1: input capture ----------------
	logic [2:0][15:0] px_s1, px_s2, px_s3, px_s4, px_s5, px_s6, px_s7, px_s8, px_s9, px_s10;
	logic le_s1, le_s2, le_s3, le_s4, le_s5, le_s6, le_s7, le_s8, le_s9, le_s10;
	logic [15:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;

	always_ff @(posedge clk) begin
		px_s1  <= {req.blue, req.green, req.red};
		le_s1  <= req.line_end;
		idx_s1 <= req.entry_index;
	end

	// ---------------- s2: coordinate product ----------------
	logic [2:0][47:0] prod_s2;

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++)
			prod_s2[ch] <= 48'(px_s1[ch]) * 48'(scale_q[ch]);
		px_s2  <= px_s1;
		le_s2  <= le_s1;
		idx_s2 <= idx_s1;
	end

	// ---------------- s3: offset and clamp ----------------
	logic [2:0][21:0] c_s3;
	logic [21:0] top;
	logic signed [33:0] csum [3];

	assign top = 22'(lv - 6'd1) << 16;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			csum[ch] = $signed({2'b00, prod_s2[ch][47:16]})
				+ $signed({{2{offset_q[ch][31]}}, offset_q[ch]});
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (csum[ch] < 0)
				c_s3[ch] <= '0;
			else if (csum[ch] > $signed({12'b0, top}))
				c_s3[ch] <= top;
			else
				c_s3[ch] <= csum[ch][21:0];
		end
		px_s3  <= px_s2;
		le_s3  <= le_s2;
		idx_s3 <= idx_s2;
	end

	// ---------------- s4: cell and fraction ----------------
	logic [2:0][5:0]  cell_s4;
	logic [2:0][16:0] fr_s4;
	logic [5:0] icell [3];
	logic [5:0] lvm2;

	assign lvm2 = lv - 6'd2;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			icell[ch] = (c_s3[ch][21:16] > lvm2) ? lvm2 : c_s3[ch][21:16];
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			cell_s4[ch] <= icell[ch];
			fr_s4[ch]   <= 17'(c_s3[ch] - (22'(icell[ch]) << 16));
		end
		px_s4  <= px_s3;
		le_s4  <= le_s3;
		idx_s4 <= idx_s3;
	end

	// ---------------- s5: tetrahedron pick and cell base ----------------
	logic [AW-1:0] base_s5, off1_s5, off2_s5;
	logic [16:0]   f1_s5, f2_s5, f3_s5;
	logic [AW-1:0] o1, o2, olv, olv2;
	logic [16:0]   f1, f2, f3;

	assign olv  = AW'(lv);
	assign olv2 = AW'(lv2_q);

	always_comb begin
		if (fr_s4[0] >= fr_s4[1]) begin
			if (fr_s4[1] >= fr_s4[2]) begin
				o1 = AW'(1); o2 = AW'(1) + olv;
				f1 = fr_s4[0]; f2 = fr_s4[1]; f3 = fr_s4[2];
			end else if (fr_s4[0] >= fr_s4[2]) begin
				o1 = AW'(1); o2 = AW'(1) + olv2;
				f1 = fr_s4[0]; f2 = fr_s4[2]; f3 = fr_s4[1];
			end else begin
				o1 = olv2; o2 = olv2 + AW'(1);
				f1 = fr_s4[2]; f2 = fr_s4[0]; f3 = fr_s4[1];
			end
		end else if (fr_s4[0] >= fr_s4[2]) begin
			o1 = olv; o2 = olv + AW'(1);
			f1 = fr_s4[1]; f2 = fr_s4[0]; f3 = fr_s4[2];
		end else if (fr_s4[1] >= fr_s4[2]) begin
			o1 = olv; o2 = olv + olv2;
			f1 = fr_s4[1]; f2 = fr_s4[2]; f3 = fr_s4[0];
		end else begin
			o1 = olv2; o2 = olv2 + olv;
			f1 = fr_s4[2]; f2 = fr_s4[1]; f3 = fr_s4[0];
		end
	end

	always_ff @(posedge clk) begin
		base_s5 <= AW'(cell_s4[0]) + AW'(cell_s4[1]) * olv + AW'(cell_s4[2]) * olv2;
		off1_s5 <= o1;
		off2_s5 <= o2;
		f1_s5   <= f1;
		f2_s5   <= f2;
		f3_s5   <= f3;
		px_s5   <= px_s4;
		le_s5   <= le_s4;
		idx_s5  <= idx_s4;
	end

	// ---------------- s6: corner addresses ----------------
	logic [AW-1:0] a0_s6, a1_s6, a2_s6, a3_s6;
	logic [16:0]   f1_s6, f2_s6, f3_s6;

	always_ff @(posedge clk) begin
		a0_s6  <= base_s5;
		a1_s6  <= base_s5 + off1_s5;
		a2_s6  <= base_s5 + off2_s5;
		a3_s6  <= base_s5 + AW'(1) + olv + olv2;
		f1_s6  <= f1_s5;
		f2_s6  <= f2_s5;
		f3_s6  <= f3_s5;
		px_s6  <= px_s5;
		le_s6  <= le_s5;
		idx_s6 <= idx_s5;
	end

	// ---------------- s7: table read/write ----------------
	// Two copies, two read ports each; writes go to both.
	logic [47:0] mem_a [DEPTH];
	logic [47:0] mem_b [DEPTH];
	logic [47:0] qa_s7, qb_s7, qc_s7, qd_s7;
	logic [16:0] f1_s7, f2_s7, f3_s7;
	logic        wr_en;

	assign wr_en = w_q[5] && (32'(idx_s6) < 32'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[AW'(idx_s6)] <= px_s6;
			mem_b[AW'(idx_s6)] <= px_s6;
		end
		qa_s7 <= mem_a[a0_s6];
		qb_s7 <= mem_a[a1_s6];
		qc_s7 <= mem_b[a2_s6];
		qd_s7 <= mem_b[a3_s6];
		f1_s7 <= f1_s6;
		f2_s7 <= f2_s6;
		f3_s7 <= f3_s6;
		px_s7 <= px_s6;
		le_s7 <= le_s6;
	end

	// ---------------- s8: weighted edge products ----------------
	logic signed [34:0] p1_s8 [3];
	logic signed [34:0] p2_s8 [3];
	logic signed [34:0] p3_s8 [3];
	logic [2:0][15:0]   a_s8;

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			p1_s8[ch] <= 35'($signed({1'b0, f1_s7})
				* ($signed({1'b0, qb_s7[ch*16 +: 16]}) - $signed({1'b0, qa_s7[ch*16 +: 16]})));
			p2_s8[ch] <= 35'($signed({1'b0, f2_s7})
				* ($signed({1'b0, qc_s7[ch*16 +: 16]}) - $signed({1'b0, qb_s7[ch*16 +: 16]})));
			p3_s8[ch] <= 35'($signed({1'b0, f3_s7})
				* ($signed({1'b0, qd_s7[ch*16 +: 16]}) - $signed({1'b0, qc_s7[ch*16 +: 16]})));
			a_s8[ch]  <= qa_s7[ch*16 +: 16];
		end
		px_s8 <= px_s7;
		le_s8 <= le_s7;
	end

	// ---------------- s9: interpolated value minus input ----------------
	logic signed [36:0] v [3];
	logic signed [34:0] d_s9 [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			v[ch] = $signed({5'b0, a_s8[ch], 16'b0}) + 37'(p1_s8[ch]) + 37'(p2_s8[ch])
				+ 37'(p3_s8[ch]) - $signed({5'b0, px_s8[ch], 16'b0});
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++)
			d_s9[ch] <= v[ch][34:0];
		px_s9 <= px_s8;
		le_s9 <= le_s8;
	end

	// ---------------- s10: strength product ----------------
	logic signed [48:0] sp_s10 [3];

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++)
			sp_s10[ch] <= 49'($signed({1'b0, str}) * d_s9[ch]);
		px_s10 <= px_s9;
		le_s10 <= le_s9;
	end

	// ---------------- blend, round, clamp into queue ----------------
	logic signed [49:0] pb [3];
	logic [49:0]        rnd [3];
	logic [15:0]        res [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			pb[ch]  = $signed({6'b0, px_s10[ch], 28'b0}) + 50'(sp_s10[ch]);
			rnd[ch] = (unsigned'(pb[ch]) + (50'd1 << 27)) >> 28;
			if (pb[ch] < 0)
				res[ch] = '0;
			else if (rnd[ch] > 50'd65535)
				res[ch] = 16'hffff;
			else
				res[ch] = rnd[ch][15:0];
		end
	end

	assign push                   = m_q[9];
	assign push_data.out_red      = res[0];
	assign push_data.out_green    = res[1];
	assign push_data.out_blue     = res[2];
	assign push_data.out_line_end = le_s10;

	// ---------------- assertions ----------------
	`LTCM_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= (FAW+1)'(FD),
		"credit count above queue depth")
	`LTCM_ASSERT_IMP(a_fill_le_cnt, clk, arst_n, 1'b1, fill_q <= cnt_q,
		"queue holds more items than credits")
	`LTCM_ASSERT_IMP(a_no_push_full, clk, arst_n, push && !pop, fill_q < (FAW+1)'(FD),
		"push into full queue")
	`LTCM_ASSERT_IMP(a_corner_range, clk, arst_n, m_q[5], 32'(a3_s6) < 32'(DEPTH),
		"corner address beyond table")
	`LTCM_ASSERT_IMP(a_frac_order, clk, arst_n, m_q[5], (f1_s6 >= f2_s6) && (f2_s6 >= f3_s6),
		"tetrahedron weights out of order")
	`LTCM_ASSERT_NXT(a_cnt_step, clk, arst_n, acc_map && !pop,
		cnt_q == $past(cnt_q) + (FAW+1)'(1), "credit not taken on map item")

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the 3D LUT tetrahedral color mapper.
// Depends on ltcm_pkg and the lut3d_tetrahedral_color_map RTL.
// Mirrors the table and registers, predicts each mapped pixel, checks in order.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = ltcm_pkg::LEVEL_MAX_DEF * ltcm_pkg::LEVEL_MAX_DEF
		* ltcm_pkg::LEVEL_MAX_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PIPE_WAIT   = 16;   // settle time that drain() waits after the last result

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ltcm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ltcm_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lut3d_tetrahedral_color_map uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the table and the registers
	logic [15:0] lut_shadow [0:STORE_DEPTH-1][3];
	bit written [STORE_DEPTH];   // corners already queued for writing by add_pixel
	logic [5:0] lvl_reg = ltcm_pkg::LEVEL_RST;
	logic [12:0] str_reg = ltcm_pkg::STRENGTH_RST;
	logic [31:0] scale_reg [3] = '{ltcm_pkg::SCALE_RST, ltcm_pkg::SCALE_RST,
		ltcm_pkg::SCALE_RST};
	logic [31:0] offset_reg [3] = '{ltcm_pkg::OFFSET_RST, ltcm_pkg::OFFSET_RST,
		ltcm_pkg::OFFSET_RST};

	ltcm_pkg::req_t pending_q [$];
	ltcm_pkg::rsp_t pixel_q [$];    // expected mapped pixels, oldest first
	int mismatches = 0;
	bit no_idle = 1'b1;   // burst mode: no gaps on either side
	bit hold_kick = 1'b0; // starts the long receiver hold-off
	int hold_left = 0;
	longint cycles = 0;

	function automatic void queue_item(ltcm_pkg::req_t it);
		pending_q = {pending_q, it};
	endfunction

	// Corner indexes and weights of a pixel under the current registers
	function automatic void locate(input ltcm_pkg::req_t it, output int unsigned corner [4],
		output longint f1, output longint f2, output longint f3);
		logic [15:0] px [3];
		longint c, top;
		int unsigned lv, lv2, off1, off2, offl, base;
		int unsigned lo_pt [3];
		int unsigned fr [3];
		px[0] = it.red; px[1] = it.green; px[2] = it.blue;
		lv = (lvl_reg < 2) ? 2 : ((lvl_reg > ltcm_pkg::LEVEL_MAX_DEF) ?
			ltcm_pkg::LEVEL_MAX_DEF : lvl_reg);
		lv2 = lv * lv;
		top = longint'(lv - 1) * 65536;
		for (int ch = 0; ch < 3; ch++) begin
			c = longint'((longint'(px[ch]) * longint'(scale_reg[ch])) >>> 16)
				+ longint'(signed'(offset_reg[ch]));
			if (c < 0) c = 0;
			if (c > top) c = top;
			lo_pt[ch] = int'(c >>> 16);
			if (lo_pt[ch] > lv - 2) lo_pt[ch] = lv - 2;
			fr[ch] = int'(c - longint'(lo_pt[ch]) * 65536);
		end
		// Six tetrahedra chosen by the order of the fractions
		if (fr[0] >= fr[1]) begin
			if (fr[1] >= fr[2]) begin
				off1 = 1; off2 = 1 + lv; f1 = fr[0]; f2 = fr[1]; f3 = fr[2];
			end else if (fr[0] >= fr[2]) begin
				off1 = 1; off2 = 1 + lv2; f1 = fr[0]; f2 = fr[2]; f3 = fr[1];
			end else begin
				off1 = lv2; off2 = lv2 + 1; f1 = fr[2]; f2 = fr[0]; f3 = fr[1];
			end
		end else if (fr[0] >= fr[2]) begin
			off1 = lv; off2 = lv + 1; f1 = fr[1]; f2 = fr[0]; f3 = fr[2];
		end else if (fr[1] >= fr[2]) begin
			off1 = lv; off2 = lv + lv2; f1 = fr[1]; f2 = fr[2]; f3 = fr[0];
		end else begin
			off1 = lv2; off2 = lv2 + lv; f1 = fr[2]; f2 = fr[1]; f3 = fr[0];
		end
		offl = 1 + lv + lv2;
		base = lo_pt[0] + lo_pt[1] * lv + lo_pt[2] * lv2;
		corner[0] = base;
		corner[1] = base + off1;
		corner[2] = base + off2;
		corner[3] = base + offl;
	endfunction

	// Tetrahedral lookup plus blend, at the block's bit widths
	function automatic ltcm_pkg::rsp_t map_pixel(ltcm_pkg::req_t it);
		logic [15:0] px [3];
		longint f1, f2, f3, a, b, cv, d, v, inq, p;
		longint unsigned r;
		int unsigned s;
		int unsigned corner [4];
		logic [15:0] res [3];
		ltcm_pkg::rsp_t o;
		px[0] = it.red; px[1] = it.green; px[2] = it.blue;
		s = (str_reg > ltcm_pkg::STRENGTH_ONE) ? ltcm_pkg::STRENGTH_ONE : str_reg;
		locate(it, corner, f1, f2, f3);
		for (int ch = 0; ch < 3; ch++) begin
			a = lut_shadow[corner[0]][ch];
			b = lut_shadow[corner[1]][ch];
			cv = lut_shadow[corner[2]][ch];
			d = lut_shadow[corner[3]][ch];
			v = a * 65536 + f1 * (b - a) + f2 * (cv - b) + f3 * (d - cv);
			inq = longint'(px[ch]) * 65536;
			p = inq * 4096 + longint'(s) * (v - inq);
			if (p < 0) p = 0;
			r = (longint'(p) + (longint'(1) << 27)) >> 28;
			res[ch] = (r > 65535) ? 16'hFFFF : r[15:0];
		end
		o.out_red = res[0];
		o.out_green = res[1];
		o.out_blue = res[2];
		o.out_line_end = it.line_end;
		return o;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: feeds pending items, shadows each accepted item
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready) begin
				if (req.action == ltcm_pkg::ACT_MAP) begin
					pixel_q = {pixel_q, map_pixel(req)};
				end else if (req.entry_index < STORE_DEPTH) begin
					lut_shadow[req.entry_index][0] = req.red;
					lut_shadow[req.entry_index][1] = req.green;
					lut_shadow[req.entry_index][2] = req.blue;
				end
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_kick && hold_left == 0) begin
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compares each taken result with the oldest expected pixel
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", rsp);
				end else begin
					ltcm_pkg::rsp_t exp_px;
					exp_px = pixel_q.pop_front();
					if (rsp !== exp_px) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: exp r%h g%h b%h le%b got r%h g%h b%h le%b",
								exp_px.out_red, exp_px.out_green, exp_px.out_blue,
								exp_px.out_line_end, rsp.out_red, rsp.out_green,
								rsp.out_blue, rsp.out_line_end);
					end
				end
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			ltcm_pkg::REG_LEVEL:        lvl_reg = val[5:0];
			ltcm_pkg::REG_STRENGTH:     str_reg = val[12:0];
			ltcm_pkg::REG_SCALE_RED:    scale_reg[0] = val;
			ltcm_pkg::REG_SCALE_GREEN:  scale_reg[1] = val;
			ltcm_pkg::REG_SCALE_BLUE:   scale_reg[2] = val;
			ltcm_pkg::REG_OFFSET_RED:   offset_reg[0] = val;
			ltcm_pkg::REG_OFFSET_GREEN: offset_reg[1] = val;
			ltcm_pkg::REG_OFFSET_BLUE:  offset_reg[2] = val;
			default: ;
		endcase
	endtask

	// Everything sent and every pixel back, then let writes settle
	task automatic drain();
		@(negedge clk);
		while (pending_q.size() > 0 || req_valid || pixel_q.size() > 0) @(negedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	function automatic ltcm_pkg::req_t pixel_item(logic [15:0] r, logic [15:0] g,
		logic [15:0] b);
		ltcm_pkg::req_t it;
		it.action = ltcm_pkg::ACT_MAP;
		it.entry_index = $urandom();
		it.red = r; it.green = g; it.blue = b;
		it.line_end = $urandom_range(0, 1);
		return it;
	endfunction

	function automatic ltcm_pkg::req_t entry_item(logic [15:0] idx);
		ltcm_pkg::req_t it;
		it.action = ltcm_pkg::ACT_WRITE;
		it.entry_index = idx;
		it.red = $urandom(); it.green = $urandom(); it.blue = $urandom();
		it.line_end = $urandom_range(0, 1);
		return it;
	endfunction

	// Queues a pixel, first writing any of its corners not yet written
	task automatic add_pixel(input logic [15:0] r, input logic [15:0] g,
		input logic [15:0] b);
		ltcm_pkg::req_t it;
		int unsigned corner [4];
		longint f1, f2, f3;
		it = pixel_item(r, g, b);
		locate(it, corner, f1, f2, f3);
		for (int k = 0; k < 4; k++) begin
			if (!written[corner[k]]) begin
				written[corner[k]] = 1'b1;
				queue_item(entry_item(16'(corner[k])));
			end
		end
		queue_item(it);
	endtask

	function automatic logic [15:0] chan_val();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return $urandom();
		endcase
	endfunction

	// Scale near the level's nominal range, sometimes at the extremes
	function automatic logic [31:0] pick_scale(int lv);
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return 32'(((64'd1 << 32) * (lv - 1)) / 65535
				+ $urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom();
			default: return $urandom_range(0, 131072) - 65536;
		endcase
	endfunction

	task automatic random_items(int n);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0)
				queue_item(entry_item(($urandom_range(0, 19) == 0) ?
					16'($urandom_range(STORE_DEPTH, 65535)) :
					16'($urandom_range(0, STORE_DEPTH - 1))));
			else
				add_pixel(chan_val(), chan_val(), chan_val());
		end
	endtask

	task automatic set_phase(int lv, int str);
		write_reg(ltcm_pkg::REG_LEVEL, lv);
		write_reg(ltcm_pkg::REG_STRENGTH, str);
		write_reg(ltcm_pkg::REG_SCALE_RED, pick_scale(lv));
		write_reg(ltcm_pkg::REG_SCALE_GREEN, pick_scale(lv));
		write_reg(ltcm_pkg::REG_SCALE_BLUE, pick_scale(lv));
		write_reg(ltcm_pkg::REG_OFFSET_RED, pick_offset());
		write_reg(ltcm_pkg::REG_OFFSET_GREEN, pick_offset());
		write_reg(ltcm_pkg::REG_OFFSET_BLUE, pick_offset());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default registers, corner pixels, dropped writes
		no_idle = 1'b0;
		add_pixel(16'h0000, 16'h0000, 16'h0000);
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pixel(16'hFFFF, 16'h0000, 16'h8000);
		add_pixel(16'h1234, 16'h1234, 16'h1234);
		// one pixel per tetrahedron: fraction orders of red, green, blue
		add_pixel(16'h0C00, 16'h0800, 16'h0400);
		add_pixel(16'h0C00, 16'h0400, 16'h0800);
		add_pixel(16'h0800, 16'h0400, 16'h0C00);
		add_pixel(16'h0800, 16'h0C00, 16'h0400);
		add_pixel(16'h0400, 16'h0C00, 16'h0800);
		add_pixel(16'h0400, 16'h0800, 16'h0C00);
		queue_item(entry_item(16'hFFFF));          // index out of range
		queue_item(entry_item(16'(STORE_DEPTH)));  // first index past the table
		queue_item(entry_item(16'h0000));
		add_pixel(16'h0000, 16'h0000, 16'h0000);
		queue_item(entry_item(16'(STORE_DEPTH - 1)));
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		drain();
		// Level below two acts as two, strength above one as one
		write_reg(ltcm_pkg::REG_LEVEL, 32'd0);
		write_reg(ltcm_pkg::REG_STRENGTH, 32'h1FFF);
		write_reg(4'd15, 32'hFFFF_FFFF);   // unknown register, no effect
		add_pixel(16'h8000, 16'h4000, 16'hC000);
		add_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		drain();
		// Level above the maximum acts as the maximum
		write_reg(ltcm_pkg::REG_LEVEL, 32'd63);
		write_reg(ltcm_pkg::REG_STRENGTH, 32'd0);
		add_pixel(16'hABCD, 16'h5432, 16'hFFFF);
		add_pixel(16'h0001, 16'hFFFE, 16'h7FFF);
		drain();

		// Random phases over several settings, extremes among them
		set_phase(2, 4096);
		random_items(25);
		drain();
		set_phase(33, 0);
		random_items(12);
		drain();
		set_phase(17, 2048);
		random_items(12);
		drain();
		set_phase(33, 4096);
		no_idle = 1'b1;
		random_items(12);
		drain();
		no_idle = 1'b0;
		set_phase($urandom_range(2, 3), $urandom_range(0, 8191));
		// receiver holds off while the sender keeps offering pixels
		hold_kick <= 1'b1;
		for (int i = 0; i < 50; i++)
			add_pixel(chan_val(), chan_val(), chan_val());
		@(posedge clk);
		hold_kick <= 1'b0;
		drain();
		set_phase($urandom_range(2, 33), $urandom_range(0, 4096));
		random_items(12);
		drain();
		set_phase(9, 4095);
		random_items(15);
		drain();

		if (mismatches == 0 && pixel_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
